// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros used by the mixer top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/msfam_pkg.sv
// ----------------------------------------------------------------------------
// msfam_pkg
// Types and constants of the multi-source frame averaging mixer.
// ----------------------------------------------------------------------------
package msfam_pkg;

    localparam int MaxSources = 4;
    localparam int QueueDepth = 3;
    localparam int FrameMax   = 1024;
    localparam int Slots      = QueueDepth + 1;
    localparam int SrcW       = 2;
    localparam int SlotW      = 2;
    localparam int PosW       = 10;
    localparam int LenW       = 11;
    localparam int AddrW      = SrcW + SlotW + PosW;

    localparam logic [1:0] MODE_PUSH    = 2'd0;
    localparam logic [1:0] MODE_MIX     = 2'd1;
    localparam logic [1:0] MODE_ENABLE  = 2'd2;
    localparam logic [1:0] MODE_DISABLE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OFF     = 3'd1;
    localparam logic [2:0] ST_STALE   = 3'd2;
    localparam logic [2:0] ST_TOOLONG = 3'd3;
    localparam logic [2:0] ST_NOMIX   = 3'd4;
    localparam logic [2:0] ST_BUSY    = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         source;
        logic [15:0]        sequence_req;
        logic signed [15:0] sample;
        logic               first_of_frame;
        logic               last_of_frame;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] mixed_sample;
        logic               mix_last;
    } t_out_word;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic signed [17:0] sum;
        logic [2:0]        count;
    } t_div_req;

endpackage

// File: sv/msfam_div.sv
// ----------------------------------------------------------------------------
// msfam_div
// Signed divide of a small sum by a source count, truncated toward zero.
// Restoring division of the magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msfam_div
    import msfam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [15:0] o_quot
);

    logic [17:0] r_rem, n_rem;
    logic [17:0] r_quo, n_quo;
    logic [17:0] r_mag, n_mag;
    logic [2:0]  r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [17:0] w_trial;
    logic [17:0] w_q;

    // One shift-subtract step per cycle.
    always_comb begin
        w_trial = {r_rem[16:0], r_mag[17]};
        n_mag   = {r_mag[16:0], 1'b0};
        if (w_trial >= {15'd0, r_den}) begin
            n_rem = w_trial - {15'd0, r_den};
            n_quo = {r_quo[16:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[16:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd18;
                r_neg  <= i_req.sum[17];
                r_mag  <= i_req.sum[17] ? 18'(-i_req.sum) : 18'(i_req.sum);
                r_den  <= i_req.count;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_mag <= n_mag;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_q    = r_neg ? 18'(-r_quo) : r_quo;
    assign o_quot = w_q[15:0];
    assign o_done = r_done;

endmodule

// File: sv/multi_source_frame_averaging_mixer.sv
// ----------------------------------------------------------------------------
// multi_source_frame_averaging_mixer
// Per-source frame queues in one sample memory, mixed by averaging.
// ----------------------------------------------------------------------------
// One word is handled at a time. Push, enable and disable words go from the idle
// state straight to the result state. A mix word steps through the four sources,
// skipping a source whose front frame does not cover the sample and, for one that
// does, issuing the read, waiting for the registered data and accumulating; it then
// runs an 18-step serial divide whose quotient becomes the result. The sample
// memory holds four frame slots of 1024 samples per source and needs no clearing
// after reset.
module multi_source_frame_averaging_mixer
    import msfam_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;

    logic signed [15:0] r_mem [0:(1 << AddrW) - 1];
    logic signed [15:0] r_rdata;
    logic               r_we;
    logic [AddrW-1:0]   r_waddr, r_raddr;
    logic signed [15:0] r_wdata;

    logic [LenW-1:0] r_slot_len [0:MaxSources*Slots-1];
    logic [SlotW-1:0] r_head [0:MaxSources-1];
    logic [1:0]       r_cnt [0:MaxSources-1];
    logic [LenW-1:0]  r_wpos [0:MaxSources-1];
    logic [MaxSources-1:0] r_rej, r_seq_ok, r_en;
    logic [15:0]      r_seq [0:MaxSources-1];
    logic [LenW-1:0]  r_mpos, r_mlen;

    logic [SrcW:0]      r_src;
    logic               r_rd_pend;
    logic signed [17:0] r_sum;
    logic [2:0]         r_n;
    t_div_req           w_req;
    logic               w_done;
    logic signed [15:0] w_quot;
    logic               r_ov;
    t_out_word          r_out;

    // Front-frame view per source for the current pass.
    logic [MaxSources-1:0] w_has;
    logic [LenW-1:0]       w_flen [0:MaxSources-1];
    logic [LenW-1:0]       w_maxlen;
    always_comb begin
        w_maxlen = '0;
        for (int s = 0; s < MaxSources; s++) begin
            w_has[s]  = r_en[s] && (r_cnt[s] != 2'd0);
            w_flen[s] = r_slot_len[{SrcW'(s), r_head[s]}];
            if (w_has[s] && w_flen[s] > w_maxlen) w_maxlen = w_flen[s];
        end
    end

    // Sample memory, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rdata <= r_mem[r_raddr];
    end

    assign w_req.start = (r_state == S_ACC) && (r_src == 3'(MaxSources)) && !r_rd_pend;
    assign w_req.sum   = r_sum;
    assign w_req.count = r_n;

    msfam_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // Sequencer; all per-word control lives here.
    always_ff @(posedge i_clk) begin
        logic [1:0]  s;
        logic [15:0] seq_gap;
        logic        rej;
        logic [SlotW-1:0] slot;
        logic [LenW-1:0]  pos;
        logic [2:0]  n_status;
        logic        n_we;
        logic        mix_end;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_we    <= 1'b0;
            r_en    <= '0;
            r_rej   <= '0;
            r_seq_ok <= '0;
            r_mpos  <= '0;
            r_mlen  <= '0;
            r_rd_pend <= 1'b0;
            for (int k = 0; k < MaxSources*Slots; k++) r_slot_len[k] <= '0;
            for (int k = 0; k < MaxSources; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
                r_wpos[k] <= '0;
                r_seq[k]  <= '0;
            end
        end else begin
            n_we = 1'b0;
            // The result word is raised after the final step and held until taken.
            r_ov <= (r_state == S_OUT) || (r_ov && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        s = i_data.source;
                        n_status = ST_OK;
                        unique case (i_data.mode)
                            MODE_PUSH: begin
                                if (!r_en[s]) n_status = ST_OFF;
                                else if (r_mlen != '0) n_status = ST_BUSY;
                                else begin
                                    rej = r_rej[s];
                                    pos = r_wpos[s];
                                    if (i_data.first_of_frame) begin
                                        pos = '0;
                                        seq_gap = i_data.sequence_req - r_seq[s];
                                        rej = r_seq_ok[s] && (seq_gap == 16'd0 || seq_gap[15]);
                                        if (!rej) begin
                                            r_seq[s] <= i_data.sequence_req;
                                            r_seq_ok[s] <= 1'b1;
                                        end
                                    end
                                    if (rej) n_status = ST_STALE;
                                    else if (pos >= LenW'(FrameMax)) begin
                                        rej = 1'b1;
                                        pos = '0;
                                        n_status = ST_TOOLONG;
                                    end else begin
                                        slot = r_head[s] + r_cnt[s];
                                        n_we    = 1'b1;
                                        r_waddr <= {s, slot, pos[PosW-1:0]};
                                        r_wdata <= i_data.sample;
                                        if (i_data.last_of_frame) begin
                                            r_slot_len[{s, slot}] <= pos + LenW'(1);
                                            pos = '0;
                                            if (r_cnt[s] >= 2'(QueueDepth))
                                                r_head[s] <= r_head[s] + 1'b1;
                                            else
                                                r_cnt[s] <= r_cnt[s] + 1'b1;
                                        end else begin
                                            pos = pos + LenW'(1);
                                        end
                                    end
                                    r_rej[s]  <= rej;
                                    r_wpos[s] <= pos;
                                end
                            end
                            MODE_MIX: begin
                                if (r_mlen == '0 && w_maxlen == '0) begin
                                    n_status = ST_NOMIX;
                                end else begin
                                    if (r_mlen == '0) begin
                                        r_mlen <= w_maxlen;
                                        r_mpos <= '0;
                                    end
                                    r_src   <= '0;
                                    r_sum   <= '0;
                                    r_n     <= '0;
                                    r_rd_pend <= 1'b0;
                                end
                            end
                            MODE_ENABLE: begin
                                if (!r_en[s]) begin
                                    r_en[s] <= 1'b1;
                                    r_head[s] <= '0; r_cnt[s] <= '0; r_wpos[s] <= '0;
                                    r_rej[s] <= 1'b0; r_seq[s] <= '0; r_seq_ok[s] <= 1'b0;
                                    for (int k = 0; k < Slots; k++)
                                        r_slot_len[{s, SlotW'(k)}] <= '0;
                                end
                            end
                            MODE_DISABLE: begin
                                if (r_mlen != '0) n_status = ST_BUSY;
                                else begin
                                    r_en[s] <= 1'b0;
                                    r_head[s] <= '0; r_cnt[s] <= '0; r_wpos[s] <= '0;
                                    r_rej[s] <= 1'b0; r_seq[s] <= '0; r_seq_ok[s] <= 1'b0;
                                    for (int k = 0; k < Slots; k++)
                                        r_slot_len[{s, SlotW'(k)}] <= '0;
                                end
                            end
                            default: ;
                        endcase
                        r_out <= {n_status, 16'd0, 1'b0};
                        if (i_data.mode == MODE_MIX && n_status == ST_OK)
                            r_state <= S_ACC;
                        else
                            r_state <= S_OUT;
                    end
                end
                S_ACC: begin
                    // Take the sample read last cycle, then issue the next read.
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_sum <= r_sum + 18'(r_rdata);
                        r_n   <= r_n + 3'd1;
                    end else if (r_src != 3'(MaxSources)) begin
                        s = r_src[SrcW-1:0];
                        if (w_has[s] && w_flen[s] > r_mpos) begin
                            r_raddr   <= {s, r_head[s], r_mpos[PosW-1:0]};
                            r_state   <= S_READ;
                        end
                        r_src <= r_src + 3'd1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_READ: begin
                    r_rd_pend <= 1'b1;
                    r_state   <= S_ACC;
                end
                S_DIV: begin
                    if (w_done) begin
                        mix_end = (r_mpos + LenW'(1)) >= r_mlen;
                        r_out <= {ST_OK, w_quot, mix_end};
                        if (mix_end) begin
                            r_mlen <= '0;
                            r_mpos <= '0;
                            for (int k = 0; k < MaxSources; k++) begin
                                if (w_has[k]) begin
                                    r_head[k] <= r_head[k] + 1'b1;
                                    r_cnt[k]  <= r_cnt[k] - 1'b1;
                                end
                            end
                        end else begin
                            r_mpos <= r_mpos + LenW'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            r_we <= n_we;
        end
    end

    // A new word is never taken while a result waits or work is in flight.
    `CHK_IMPLY(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    // The final sequencer step is always followed by a result.
    `CHK_NEXT(a_out_after_step, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    // A pass is never longer than the longest frame a slot can hold.
    `CHK_IMPLY(a_mlen_bound, i_clk, i_rst_n, 1'b1, r_mlen <= LenW'(FrameMax))

endmodule

// File: test/multi_source_frame_averaging_mixer_test.sv
// ----------------------------------------------------------------------------
// multi_source_frame_averaging_mixer_test
// Drives push, mix, enable and disable words into the mixer. A scoreboard
// predicts each answer word from its own copy of the source queues, and
// compares every answer word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_source_frame_averaging_mixer_test;
    import msfam_pkg::*;

    // Predicts the mixer answers and holds them until they come out.
    class mixer_scoreboard;
        logic signed [15:0] pcm [MaxSources][Slots][FrameMax];
        int unsigned frame_len [MaxSources][Slots];
        int unsigned head [MaxSources];
        int unsigned depth [MaxSources];
        int unsigned wr_pos [MaxSources];
        bit          dropping [MaxSources];
        logic [15:0] last_seq [MaxSources];
        bit          seq_known [MaxSources];
        bit          enabled [MaxSources];
        int unsigned pass_pos;
        int unsigned pass_len;
        t_out_word   awaited [$];
        int          mismatches;

        function new();
            for (int s = 0; s < MaxSources; s++) begin
                clear_source(s);
                enabled[s] = 0;
            end
            pass_pos = 0;
            pass_len = 0;
            mismatches = 0;
            for (int s = 0; s < MaxSources; s++)
                for (int k = 0; k < Slots; k++)
                    for (int p = 0; p < FrameMax; p++)
                        pcm[s][k][p] = '0;
        endfunction

        function void clear_source(int s);
            head[s] = 0;
            depth[s] = 0;
            wr_pos[s] = 0;
            dropping[s] = 0;
            last_seq[s] = '0;
            seq_known[s] = 0;
            for (int k = 0; k < Slots; k++)
                frame_len[s][k] = 0;
        endfunction

        function logic [2:0] push_sample(t_in_word w);
            int s;
            int unsigned slot;
            logic [15:0] seq_gap;
            s = w.source;
            if (!enabled[s])
                return ST_OFF;
            if (pass_len != 0)
                return ST_BUSY;
            if (w.first_of_frame) begin
                wr_pos[s] = 0;
                dropping[s] = 0;
                if (seq_known[s]) begin
                    seq_gap = w.sequence_req - last_seq[s];
                    if (seq_gap == 16'h0 || seq_gap[15])
                        dropping[s] = 1;
                end
                if (!dropping[s]) begin
                    last_seq[s] = w.sequence_req;
                    seq_known[s] = 1;
                end
            end
            if (dropping[s])
                return ST_STALE;
            if (wr_pos[s] >= FrameMax) begin
                dropping[s] = 1;
                wr_pos[s] = 0;
                return ST_TOOLONG;
            end
            slot = (head[s] + depth[s]) % Slots;
            pcm[s][slot][wr_pos[s]] = w.sample;
            wr_pos[s]++;
            if (w.last_of_frame) begin
                frame_len[s][slot] = wr_pos[s];
                wr_pos[s] = 0;
                if (depth[s] >= QueueDepth)
                    head[s] = (head[s] + 1) % Slots;
                else
                    depth[s]++;
            end
            return ST_OK;
        endfunction

        function void mix_sample(ref t_out_word r);
            int unsigned len;
            int sum;
            int cnt;
            len = 0;
            sum = 0;
            cnt = 0;
            if (pass_len == 0) begin
                for (int s = 0; s < MaxSources; s++)
                    if (enabled[s] && depth[s] > 0 && frame_len[s][head[s]] > len)
                        len = frame_len[s][head[s]];
                if (len == 0) begin
                    r.status = ST_NOMIX;
                    return;
                end
                pass_len = len;
                pass_pos = 0;
            end
            for (int s = 0; s < MaxSources; s++)
                if (enabled[s] && depth[s] > 0 && frame_len[s][head[s]] > pass_pos) begin
                    sum += pcm[s][head[s]][pass_pos];
                    cnt++;
                end
            if (cnt > 0)
                r.mixed_sample = 16'(sum / cnt);
            pass_pos++;
            if (pass_pos >= pass_len) begin
                for (int s = 0; s < MaxSources; s++)
                    if (enabled[s] && depth[s] > 0) begin
                        head[s] = (head[s] + 1) % Slots;
                        depth[s]--;
                    end
                pass_len = 0;
                pass_pos = 0;
                r.mix_last = 1'b1;
            end
        endfunction

        // Notes an accepted input word and queues the answer it must cause.
        function void note_word(t_in_word w);
            t_out_word r;
            r = '0;
            r.status = ST_OK;
            case (w.mode)
                MODE_PUSH: r.status = push_sample(w);
                MODE_MIX: mix_sample(r);
                MODE_ENABLE: begin
                    if (!enabled[w.source]) begin
                        clear_source(w.source);
                        enabled[w.source] = 1;
                    end
                end
                default: begin
                    if (pass_len != 0) begin
                        r.status = ST_BUSY;
                    end else begin
                        clear_source(w.source);
                        enabled[w.source] = 0;
                    end
                end
            endcase
            awaited.push_back(r);
        endfunction

        // Checks an answer word against the oldest awaited one.
        function void check_word(t_out_word r);
            t_out_word e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer word: status %0d sample %0d last %0d",
                             r.status, r.mixed_sample, r.mix_last);
                return;
            end
            e = awaited[0];
            awaited.delete(0);
            if (r.status !== e.status || r.mixed_sample !== e.mixed_sample ||
                r.mix_last !== e.mix_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             e.status, e.mixed_sample, e.mix_last,
                             r.status, r.mixed_sample, r.mix_last);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    mixer_scoreboard sb = new();
    int  tx_idle_pct = 13;
    int  rx_idle_pct = 66;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  words_sent = 0;
    logic [15:0] next_seq [MaxSources];

    multi_source_frame_averaging_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Observe both handshakes and keep the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_word(i_data);
            if (o_valid && i_ready)
                sb.check_word(o_data);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000) begin
                $display("multi_source_frame_averaging_mixer_test: errors");
                $finish;
            end
        end
    end

    // Receiver side: random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offers one word and waits until it is taken; valid stays up afterwards.
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic send_op(logic [1:0] mode, logic [1:0] src, logic [15:0] seq,
                           logic signed [15:0] smp, logic fst, logic lst);
        t_in_word w;
        w.mode = mode;
        w.source = src;
        w.sequence_req = seq;
        w.sample = smp;
        w.first_of_frame = fst;
        w.last_of_frame = lst;
        send_word(w);
    endtask

    // Pushes one frame of random content with a chosen sequence number.
    task automatic send_frame(logic [1:0] src, logic [15:0] seq, int len);
        for (int p = 0; p < len; p++)
            send_op(MODE_PUSH, src, seq, 16'($urandom), p == 0, p == len - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    // Random traffic: mostly well-formed frames and mix runs.
    task automatic random_traffic(int count);
        int goal;
        int pick;
        logic [1:0] src;
        logic [15:0] seq;
        goal = words_sent + count;
        while (words_sent < goal) begin
            pick = $urandom_range(99);
            src = 2'($urandom);
            if (pick < 55) begin
                seq = next_seq[src];
                case ($urandom_range(9))
                    0: seq = next_seq[src] - 16'd1;
                    1: seq = next_seq[src] + 16'h7fff + 16'($urandom_range(32768));
                    2: seq = next_seq[src] + 16'($urandom_range(300));
                    default: ;
                endcase
                next_seq[src] = seq + 16'd1;
                if ($urandom_range(19) == 0)
                    send_op(MODE_PUSH, src, 16'($urandom), 16'($urandom), 1'b0,
                            1'($urandom_range(1)));
                else
                    send_frame(src, seq, ($urandom_range(9) == 0) ?
                               $urandom_range(40) + 1 : $urandom_range(6) + 1);
            end else if (pick < 85) begin
                repeat ($urandom_range(10) + 1)
                    send_op(MODE_MIX, src, 16'($urandom), 16'($urandom),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (pick < 93) begin
                send_op(MODE_ENABLE, src, 16'($urandom), 16'($urandom),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (pick < 96) begin
                send_op(MODE_DISABLE, src, 16'($urandom), 16'($urandom),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                send_word(t_in_word'(38'({$urandom, $urandom})));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < MaxSources; s++)
            next_seq[s] = 16'($urandom);

        // Directed: nothing to mix, a push to an off source, a disable, enables.
        send_op(MODE_MIX, 2'd0, 16'h0, 16'sh0, 1'b0, 1'b0);
        send_op(MODE_PUSH, 2'd1, 16'hffff, 16'sh7fff, 1'b1, 1'b1);
        send_op(MODE_DISABLE, 2'd2, 16'h0, 16'sh0, 1'b0, 1'b0);
        for (int s = 0; s < MaxSources; s++)
            send_op(MODE_ENABLE, 2'(s), 16'h0, 16'sh0, 1'b0, 1'b0);
        send_op(MODE_ENABLE, 2'd3, 16'h0, 16'sh0, 1'b0, 1'b0);
        // Extreme samples and a truncating negative average.
        send_op(MODE_PUSH, 2'd0, 16'hffff, 16'sh7fff, 1'b1, 1'b0);
        send_op(MODE_PUSH, 2'd0, 16'hffff, -16'sd1, 1'b0, 1'b1);
        send_op(MODE_PUSH, 2'd1, 16'h0000, -16'sd32768, 1'b1, 1'b0);
        send_op(MODE_PUSH, 2'd1, 16'h0000, -16'sd2, 1'b0, 1'b0);
        send_op(MODE_PUSH, 2'd1, 16'h0000, 16'sd5, 1'b0, 1'b1);
        // Stale sequences: same number, then a distance of exactly 0x8000.
        send_op(MODE_PUSH, 2'd0, 16'hffff, 16'sd9, 1'b1, 1'b1);
        send_op(MODE_PUSH, 2'd1, 16'h8000, 16'sd9, 1'b1, 1'b0);
        send_op(MODE_PUSH, 2'd1, 16'h8000, 16'sd9, 1'b0, 1'b1);
        // Sample without a first mark lands on the open frame.
        send_op(MODE_PUSH, 2'd2, 16'h1234, 16'sd100, 1'b0, 1'b1);
        // Open a pass, then push and disable are refused as busy.
        send_op(MODE_MIX, 2'd0, 16'h0, 16'sh0, 1'b0, 1'b0);
        send_op(MODE_PUSH, 2'd3, 16'h0001, 16'sh0, 1'b1, 1'b1);
        send_op(MODE_DISABLE, 2'd0, 16'h0, 16'sh0, 1'b0, 1'b0);
        repeat (3) send_op(MODE_MIX, 2'd0, 16'h0, 16'sh0, 1'b0, 1'b0);
        // A frame longer than the maximum, then its tail answers stale.
        send_frame(2'd3, 16'h0010, FrameMax + 1);
        send_op(MODE_PUSH, 2'd3, 16'h0, 16'sd1, 1'b0, 1'b0);
        send_op(MODE_PUSH, 2'd3, 16'h0, 16'sd1, 1'b0, 1'b1);
        send_op(MODE_DISABLE, 2'd3, 16'h0, 16'sh0, 1'b0, 1'b0);
        drain();

        // Phase one; the receiver then holds off while words keep coming.
        random_traffic(280);
        hold_req = 1;
        random_traffic(40);
        // Phase two, then a full pause until every answer has come back.
        tx_idle_pct = 66;
        rx_idle_pct = 13;
        random_traffic(280);
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(300);
        drain();
        repeat (50) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("multi_source_frame_averaging_mixer_test: clean");
        else
            $display("multi_source_frame_averaging_mixer_test: errors");
        $finish;
    end

endmodule
